// ===== design/lss_pkg.sv =====
`timescale 1ns / 1ps

package lss_pkg;

   localparam int DEFAULT_STACK_DEPTH = 16;

   localparam int WORD_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_BOTTOM = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_SORT   = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {RD_TOP, RD_IDX, RD_IDX_M1, RD_IDX_P1, RD_ZERO} rd_sel_type;
   typedef enum logic [2:0] {WR_COUNT, WR_IDX, WR_IDX_M1, WR_LIM, WR_ZERO} wr_sel_type;
   typedef enum logic [1:0] {WD_OPND, WD_RDATA, WD_HOLD, WD_MAX} wd_sel_type;
   typedef enum logic [2:0] {IDX_KEEP, IDX_TOP, IDX_COUNT, IDX_ONE, IDX_INC, IDX_DEC} idx_op_type;
   typedef enum logic [1:0] {LIM_KEEP, LIM_TOP, LIM_DEC} lim_op_type;

   typedef struct packed {
      logic       load_opnd;
      logic       res_clear;
      logic       res_empty;
      logic       res_full;
      logic       res_notfound;
      logic       res_hit;
      logic       res_rdata;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      wd_sel_type wd_sel;
      logic       count_inc;
      logic       count_dec;
      idx_op_type idx_op;
      lim_op_type lim_op;
      logic       hold_load;
      logic       hold_sort;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic few;
      logic idx_zero;
      logic idx_one;
      logic idx_at_lim;
      logic lim_one;
      logic match;
   } dp_stat_type;

endpackage

// ===== design/lss_datapath.sv =====
`timescale 1ns / 1ps

module lss_datapath import lss_pkg::*; #(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [WORD_W-1:0]   req_operand_value,
   input  dp_cmd_type                 cmd,
   output dp_stat_type                stat,
   output logic signed [WORD_W-1:0]   rsp_result_value,
   output logic        [POS_W-1:0]    rsp_match_position,
   output logic        [COUNT_W-1:0]  rsp_entry_count,
   output logic        [STATUS_W-1:0] rsp_status
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic signed [WORD_W-1:0] mem [STACK_DEPTH];

   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic [AW-1:0]            lim_ff, lim_in;
   logic signed [WORD_W-1:0] hold_ff, hold_in;
   logic signed [WORD_W-1:0] opnd_ff, opnd_in;
   logic signed [WORD_W-1:0] rdata_ff;
   logic signed [WORD_W-1:0] res_value_ff, res_value_in;
   logic [POS_W-1:0]         res_pos_ff, res_pos_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic signed [WORD_W-1:0] out_value_ff;
   logic [POS_W-1:0]         out_pos_ff;
   logic [COUNT_W-1:0]       out_count_ff;
   logic [STATUS_W-1:0]      out_status_ff;

   logic [AW-1:0]            top_idx;
   logic [CW-1:0]            hit_pos;
   logic                     hold_less;
   logic [AW-1:0]            rd_addr;
   logic [AW-1:0]            wr_addr;
   logic signed [WORD_W-1:0] wr_data;

   assign top_idx   = AW'(count_ff - CW'(1));
   assign hit_pos   = count_ff - CW'(1) - CW'(idx_ff);
   assign hold_less = hold_ff < rdata_ff;

   assign stat.empty      = (count_ff == '0);
   assign stat.full       = (count_ff == CW'(STACK_DEPTH));
   assign stat.few        = (count_ff < CW'(2));
   assign stat.idx_zero   = (idx_ff == '0);
   assign stat.idx_one    = (idx_ff == AW'(1));
   assign stat.idx_at_lim = (idx_ff == lim_ff);
   assign stat.lim_one    = (lim_ff == AW'(1));
   assign stat.match      = (rdata_ff == opnd_ff);

   always_comb begin
      case (cmd.rd_sel)
         RD_TOP:    rd_addr = top_idx;
         RD_IDX:    rd_addr = idx_ff;
         RD_IDX_M1: rd_addr = idx_ff - AW'(1);
         RD_IDX_P1: rd_addr = idx_ff + AW'(1);
         RD_ZERO:   rd_addr = '0;
         default:   rd_addr = '0;
      endcase
      case (cmd.wr_sel)
         WR_COUNT:  wr_addr = AW'(count_ff);
         WR_IDX:    wr_addr = idx_ff;
         WR_IDX_M1: wr_addr = idx_ff - AW'(1);
         WR_LIM:    wr_addr = lim_ff;
         WR_ZERO:   wr_addr = '0;
         default:   wr_addr = '0;
      endcase
      case (cmd.wd_sel)
         WD_OPND:  wr_data = opnd_ff;
         WD_RDATA: wr_data = rdata_ff;
         WD_HOLD:  wr_data = hold_ff;
         WD_MAX:   wr_data = hold_less ? rdata_ff : hold_ff;
         default:  wr_data = opnd_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end

      case (cmd.idx_op)
         IDX_KEEP:  idx_in = idx_ff;
         IDX_TOP:   idx_in = top_idx;
         IDX_COUNT: idx_in = AW'(count_ff);
         IDX_ONE:   idx_in = AW'(1);
         IDX_INC:   idx_in = idx_ff + AW'(1);
         IDX_DEC:   idx_in = idx_ff - AW'(1);
         default:   idx_in = idx_ff;
      endcase

      case (cmd.lim_op)
         LIM_KEEP: lim_in = lim_ff;
         LIM_TOP:  lim_in = top_idx;
         LIM_DEC:  lim_in = lim_ff - AW'(1);
         default:  lim_in = lim_ff;
      endcase

      hold_in = hold_ff;
      if (cmd.hold_load) begin
         hold_in = rdata_ff;
      end else if (cmd.hold_sort) begin
         hold_in = hold_less ? hold_ff : rdata_ff;
      end

      opnd_in = cmd.load_opnd ? req_operand_value : opnd_ff;

      res_value_in  = res_value_ff;
      res_pos_in    = res_pos_ff;
      res_status_in = res_status_ff;
      if (cmd.res_clear) begin
         res_value_in  = '0;
         res_pos_in    = '0;
         res_status_in = STATUS_OK;
      end
      if (cmd.res_empty) begin
         res_value_in  = WORD_MIN;
         res_status_in = STATUS_EMPTY;
      end
      if (cmd.res_full) begin
         res_status_in = STATUS_FULL;
      end
      if (cmd.res_notfound) begin
         res_status_in = STATUS_NOTFOUND;
      end
      if (cmd.res_hit) begin
         res_pos_in    = POS_W'(hit_pos);
         res_status_in = STATUS_OK;
      end
      if (cmd.res_rdata) begin
         res_value_in = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      idx_ff        <= idx_in;
      lim_ff        <= lim_in;
      hold_ff       <= hold_in;
      opnd_ff       <= opnd_in;
      res_value_ff  <= res_value_in;
      res_pos_ff    <= res_pos_in;
      res_status_ff <= res_status_in;
      if (cmd.out_load) begin
         out_value_ff  <= res_value_ff;
         out_pos_ff    <= res_pos_ff;
         out_count_ff  <= COUNT_W'(count_ff);
         out_status_ff <= res_status_ff;
      end
   end

   assign rsp_result_value   = out_value_ff;
   assign rsp_match_position = out_pos_ff;
   assign rsp_entry_count    = out_count_ff;
   assign rsp_status         = out_status_ff;

endmodule

// ===== design/lss_ctrl.sv =====
`timescale 1ns / 1ps

module lss_ctrl import lss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dp_cmd_type        cmd,
   input  dp_stat_type       stat
);

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_RDWAIT, S_SRCH_RD, S_SRCH_CMP, S_BOT_RD, S_BOT_WR,
      S_BOT_FIN, S_SORT_LOAD, S_SORT_STEP, S_SORT_PEND, S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      func_in  = func_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_opnd = 1'b1;
               func_in       = req_func;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.res_clear = 1'b1;
            state_in      = S_RESP;
            case (func_ff)
               FUNC_PUSH: begin
                  if (stat.full) begin
                     cmd.res_full = 1'b1;
                  end else begin
                     cmd.wr_en     = 1'b1;
                     cmd.wr_sel    = WR_COUNT;
                     cmd.wd_sel    = WD_OPND;
                     cmd.count_inc = 1'b1;
                  end
               end
               FUNC_POP, FUNC_PEEK: begin
                  if (stat.empty) begin
                     cmd.res_empty = 1'b1;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_TOP;
                     state_in   = S_RDWAIT;
                  end
               end
               FUNC_SEARCH: begin
                  cmd.res_notfound = 1'b1;
                  if (!stat.empty) begin
                     cmd.idx_op = IDX_TOP;
                     state_in   = S_SRCH_RD;
                  end
               end
               FUNC_BOTTOM: begin
                  if (stat.full) begin
                     cmd.res_full = 1'b1;
                  end else if (stat.empty) begin
                     state_in = S_BOT_FIN;
                  end else begin
                     cmd.idx_op = IDX_COUNT;
                     state_in   = S_BOT_RD;
                  end
               end
               FUNC_SORT: begin
                  if (!stat.few) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ZERO;
                     cmd.idx_op = IDX_ONE;
                     cmd.lim_op = LIM_TOP;
                     state_in   = S_SORT_LOAD;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_RDWAIT: begin
            cmd.res_rdata = 1'b1;
            cmd.count_dec = (func_ff == FUNC_POP);
            state_in      = S_RESP;
         end
         S_SRCH_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (stat.match) begin
               cmd.res_hit = 1'b1;
               state_in    = S_RESP;
            end else if (stat.idx_zero) begin
               state_in = S_RESP;
            end else begin
               cmd.idx_op = IDX_DEC;
               state_in   = S_SRCH_RD;
            end
         end
         S_BOT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX_M1;
            state_in   = S_BOT_WR;
         end
         S_BOT_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_IDX;
            cmd.wd_sel = WD_RDATA;
            if (stat.idx_one) begin
               state_in = S_BOT_FIN;
            end else begin
               cmd.idx_op = IDX_DEC;
               state_in   = S_BOT_RD;
            end
         end
         S_BOT_FIN: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_ZERO;
            cmd.wd_sel    = WD_OPND;
            cmd.count_inc = 1'b1;
            state_in      = S_RESP;
         end
         S_SORT_LOAD: begin
            cmd.hold_load = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_IDX;
            state_in      = S_SORT_STEP;
         end
         S_SORT_STEP: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_IDX_M1;
            cmd.wd_sel    = WD_MAX;
            cmd.hold_sort = 1'b1;
            if (stat.idx_at_lim) begin
               state_in = S_SORT_PEND;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_P1;
               cmd.idx_op = IDX_INC;
            end
         end
         S_SORT_PEND: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_LIM;
            cmd.wd_sel = WD_HOLD;
            if (stat.lim_one) begin
               state_in = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ZERO;
               cmd.idx_op = IDX_ONE;
               cmd.lim_op = LIM_DEC;
               state_in   = S_SORT_LOAD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;
   end

endmodule

// ===== design/lifo_stack_with_search_and_sort.sv =====
`timescale 1ns / 1ps

// Bounded LIFO stack of signed 32-bit words held in one on-chip memory with a single write
// port and a single registered read port, so every operation is sequenced one word at a time.
// One word is taken at a time and answered with exactly one word; the answer sits in an output
// register, so the next word is taken while it waits. Search visits entries from the top down,
// and bottom insert shifts every held entry up one place before writing the new word at the
// bottom. Sort is a bubble sort through the read port and runs on two or more held entries.
// The block is ready again in the cycle its answer appears; if an earlier answer is still
// waiting in the output register, the block holds its own answer until that one is taken.

module lifo_stack_with_search_and_sort import lss_pkg::*; #(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic        [FUNC_W-1:0]   req_func,
   input  logic signed [WORD_W-1:0]   req_operand_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [WORD_W-1:0]   rsp_result_value,
   output logic        [POS_W-1:0]    rsp_match_position,
   output logic        [COUNT_W-1:0]  rsp_entry_count,
   output logic        [STATUS_W-1:0] rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   lss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   lss_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_operand_value  (req_operand_value),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_result_value   (rsp_result_value),
      .rsp_match_position (rsp_match_position),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_status         (rsp_status)
   );

endmodule

// ===== design/lss_checker.sv =====
`timescale 1ns / 1ps

module lss_checker import lss_pkg::*; #(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [WORD_W-1:0]   rsp_result_value,
   input logic        [POS_W-1:0]    rsp_match_position,
   input logic        [COUNT_W-1:0]  rsp_entry_count,
   input logic        [STATUS_W-1:0] rsp_status
);

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(STACK_DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("Stalled response word changed or was dropped.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request taken again before the previous word was finished.");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |->
         rsp_result_value == WORD_MIN && rsp_entry_count == '0 && rsp_match_position == '0)
      else $error("Empty status with inconsistent response fields.");

   a_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         rsp_entry_count == FULL_COUNT && rsp_result_value == '0)
      else $error("Full status reported while the stack was not full.");

   a_notfound_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NOTFOUND |->
         rsp_match_position == '0 && rsp_result_value == '0)
      else $error("Search miss with a nonzero position or value.");

endmodule

bind lifo_stack_with_search_and_sort lss_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_lss_checker (.*);
